// ===== rtl/vao_pkg.sv =====
// Shared types and constants for the voice allocator.
// Holds field widths, request and action codes, and the scan and commit records.
// No dependencies.
package vao_pkg;

   localparam int OP_W    = 2;
   localparam int NOTE_W  = 7;
   localparam int TIME_W  = 32;
   localparam int ACT_W   = 3;
   localparam int VOICE_W = 4;

   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;

   localparam logic [ACT_W-1:0] ACT_IGNORED      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_STARTED      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_STOLEN       = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RELEASED     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_ALL_RELEASED = 3'd4;

   // Search record that walks down the row of voice cells.
   typedef struct packed {
      logic               valid;
      logic [NOTE_W-1:0]  note;
      logic               free_hit;
      logic [VOICE_W-1:0] free_idx;
      logic               match_hit;
      logic [VOICE_W-1:0] match_idx;
      logic [VOICE_W-1:0] old_idx;
      logic [TIME_W-1:0]  old_time;
   } scan_type;

   // Update broadcast from the controller to every cell.
   typedef struct packed {
      logic               start;
      logic               release_one;
      logic               clear_all;
      logic [VOICE_W-1:0] idx;
      logic [NOTE_W-1:0]  note;
      logic [TIME_W-1:0]  stamp;
   } commit_type;

endpackage

// ===== rtl/vao_cell.sv =====
// One voice of the allocator: active bit, note and start time.
// Updates the passing search record and registers it for the next cell.
// Depends on vao_pkg.
module vao_cell #(
   parameter logic [vao_pkg::VOICE_W-1:0] VOICE_ID = '0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vao_pkg::scan_type    scan_in,
   output vao_pkg::scan_type    scan_out,
   input  vao_pkg::commit_type  commit
);
   import vao_pkg::*;

   logic              active_ff, active_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [TIME_W-1:0] time_ff, time_in;
   scan_type          scan_ff, scan_in_nx;

   // Fold this voice into the search record.
   always_comb begin
      scan_in_nx = scan_in;
      if (scan_in.valid) begin
         if (!scan_in.free_hit && !active_ff) begin
            scan_in_nx.free_hit = 1'b1;
            scan_in_nx.free_idx = VOICE_ID;
         end
         if (!scan_in.match_hit && active_ff && (note_ff == scan_in.note)) begin
            scan_in_nx.match_hit = 1'b1;
            scan_in_nx.match_idx = VOICE_ID;
         end
         // strict compare keeps the lowest index on a tie
         if (time_ff < scan_in.old_time) begin
            scan_in_nx.old_idx  = VOICE_ID;
            scan_in_nx.old_time = time_ff;
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      note_in   = note_ff;
      time_in   = time_ff;
      if (commit.clear_all) begin
         active_in = 1'b0;
         note_in   = '0;
      end else if (commit.start && (commit.idx == VOICE_ID)) begin
         active_in = 1'b1;
         note_in   = commit.note;
         time_in   = commit.stamp;
      end else if (commit.release_one && (commit.idx == VOICE_ID)) begin
         active_in = 1'b0;
         note_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         note_ff       <= '0;
         time_ff       <= '0;
         scan_ff.valid <= 1'b0;
      end else begin
         active_ff     <= active_in;
         note_ff       <= note_in;
         time_ff       <= time_in;
         scan_ff.valid <= scan_in_nx.valid;
      end
      scan_ff.note      <= scan_in_nx.note;
      scan_ff.free_hit  <= scan_in_nx.free_hit;
      scan_ff.free_idx  <= scan_in_nx.free_idx;
      scan_ff.match_hit <= scan_in_nx.match_hit;
      scan_ff.match_idx <= scan_in_nx.match_idx;
      scan_ff.old_idx   <= scan_in_nx.old_idx;
      scan_ff.old_time  <= scan_in_nx.old_time;
   end

   assign scan_out = scan_ff;

endmodule

// ===== rtl/voice_allocator_oldest_steal.sv =====
// Polyphonic voice allocator with oldest-voice stealing (top level).
// A request passes through the row of NUM_VOICES cell registers, the found register and the
// output register, one item at a time; the search record walks one voice cell per cycle, and the
// next request is accepted only after the current one is committed. A new request is taken while
// the previous result waits in the output register.
// Reset (synchronous, active high) clears every voice, the ready flag and both handshakes.
module voice_allocator_oldest_steal #(
   parameter int NUM_VOICES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [39:0]                         req_tdata,  // [6:0] note, [38:7] timestamp
   input  logic [vao_pkg::OP_W-1:0]            req_tuser,  // [1:0] op
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [3:0] voice
   output logic [vao_pkg::ACT_W-1:0]           rsp_tuser,  // [2:0] action
   // instrument_ready register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_data
);
   import vao_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [NOTE_W-1:0]  note_ff, note_in;
   logic [TIME_W-1:0]  stamp_ff, stamp_in;
   scan_type           found_ff, found_in;
   logic               ready_ff, ready_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]   rsp_action_ff, rsp_action_in;
   logic [VOICE_W-1:0] rsp_voice_ff, rsp_voice_in;

   scan_type           scan_w [NUM_VOICES+1];
   commit_type         commit;
   logic               req_take;
   logic               commit_fire;
   logic [ACT_W-1:0]   act;
   logic [VOICE_W-1:0] vidx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Launch a fresh search record into the first cell on each accepted request.
   always_comb begin
      scan_w[0].valid     = req_take;
      scan_w[0].note      = req_tdata[6:0];
      scan_w[0].free_hit  = 1'b0;
      scan_w[0].free_idx  = '0;
      scan_w[0].match_hit = 1'b0;
      scan_w[0].match_idx = '0;
      scan_w[0].old_idx   = '0;
      scan_w[0].old_time  = '1;
   end

   // Row of voice cells; each hands the record to the next one per cycle.
   for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
      vao_cell #(
         .VOICE_ID (VOICE_W'(i))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (scan_w[i]),
         .scan_out (scan_w[i+1]),
         .commit   (commit)
      );
   end

   // Turn the finished search into an action; commit only once the output is free.
   assign commit_fire = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      act  = ACT_IGNORED;
      vidx = '0;
      case (op_ff)
         OP_NOTE_ON: begin
            if (ready_ff) begin
               if (found_ff.free_hit) begin
                  act  = ACT_STARTED;
                  vidx = found_ff.free_idx;
               end else begin
                  act  = ACT_STOLEN;
                  vidx = found_ff.old_idx;
               end
            end
         end
         OP_NOTE_OFF: begin
            if (found_ff.match_hit) begin
               act  = ACT_RELEASED;
               vidx = found_ff.match_idx;
            end
         end
         OP_ALL_OFF: begin
            act = ACT_ALL_RELEASED;
         end
         default: begin
            act = ACT_IGNORED;
         end
      endcase
   end

   always_comb begin
      commit.start       = commit_fire && ((act == ACT_STARTED) || (act == ACT_STOLEN));
      commit.release_one = commit_fire && (act == ACT_RELEASED);
      commit.clear_all   = commit_fire && (act == ACT_ALL_RELEASED);
      commit.idx         = vidx;
      commit.note        = note_ff;
      commit.stamp       = stamp_ff;
   end

   // Sequencer: hold the request, wait for the record to leave the last cell, decide.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      note_in  = note_ff;
      stamp_in = stamp_ff;
      found_in = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in    = req_tuser;
               note_in  = req_tdata[6:0];
               stamp_in = req_tdata[38:7];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_w[NUM_VOICES].valid) begin
               found_in = scan_w[NUM_VOICES];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (commit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on commit, drop once the result transaction completes.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_action_in = rsp_action_ff;
      rsp_voice_in  = rsp_voice_ff;
      if (commit_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = act;
         rsp_voice_in  = vidx;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign ready_in = (csr_valid && csr_ready) ? csr_data : ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      note_ff       <= note_in;
      stamp_ff      <= stamp_in;
      found_ff      <= found_in;
      rsp_action_ff <= rsp_action_in;
      rsp_voice_ff  <= rsp_voice_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tdata  = {{(8-VOICE_W){1'b0}}, rsp_voice_ff};

   // The search record reaches the end of the row once it has passed through each of the NUM_VOICES cell registers.
   a_scan_arrives: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##(NUM_VOICES) scan_w[NUM_VOICES].valid)
      else $error("search record did not leave the last cell on time");

   // A record leaves the row only while the sequencer waits for it.
   a_scan_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_w[NUM_VOICES].valid |-> (state_ff == ST_SCAN))
      else $error("search record arrived outside the scan state");

   // At most one kind of update goes to the cells at a time.
   a_commit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({commit.start, commit.release_one, commit.clear_all}))
      else $error("conflicting voice updates");

   // Started or released voices always exist.
   a_commit_idx: assert property (@(posedge clock) disable iff (reset)
      (commit.start || commit.release_one) |->
         ({1'b0, commit.idx} < (VOICE_W+1)'(NUM_VOICES)))
      else $error("update addressed a voice beyond the row");

   // A commit always produces a result in the next cycle.
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit_fire |=> rsp_valid_ff && (rsp_action_ff == $past(act)))
      else $error("committed action not presented as a result");

endmodule
